/* hw/rtl/icwp_pkg.sv */
package icwp_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int COUNT_BITS  = 16;
    localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
    localparam int N_BITS      = $clog2(MAX_ENTRIES + 1);
    localparam int CFG_BITS    = 7;
    localparam int RND_BITS    = 32;
    // 10*max fits in COUNT_BITS+4 bits; the sum of weights adds IDX_BITS more.
    localparam int NUM_BITS    = COUNT_BITS + 4;
    localparam int SUM_BITS    = NUM_BITS + IDX_BITS + 1;
    localparam int NUM_CNT_W   = $clog2(NUM_BITS + 1);
    localparam int RND_CNT_W   = $clog2(RND_BITS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_ACT   = 2'd1;
    localparam logic [1:0] ST_ZERO_CNT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAX_RD,
        S_MAX_CHK,
        S_SUM_RD,
        S_SUM_DIV,
        S_SUM_ADD,
        S_MOD,
        S_WALK_RD,
        S_WALK_DIV,
        S_WALK_CHK,
        S_UPDATE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load_item;   // capture the accepted word
        logic write_load;  // write the loaded count
        logic clr_idx;     // index and accumulators to zero
        logic rd;          // read table at index, or at the pick on an update
        logic max_step;    // fold read value into max
        logic div_start;
        logic sum_add;
        logic mod_start;
        logic run_add;
        logic idx_inc;
        logic upd_write;   // saturating increment of the pick
        logic set_pick;    // take index as pick
        logic set_status;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic last_idx;    // index is at n-1
        logic n_zero;
        logic rd_zero;     // read value is zero
        logic div_busy;
        logic mod_busy;
        logic run_gt;      // running sum plus current weight above the residue
    } sts_t;

endpackage

/* hw/rtl/icwp_datapath.sv */
module icwp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  icwp_pkg::cmd_t                    cmd,
    output icwp_pkg::sts_t                    sts,
    input  logic [icwp_pkg::CFG_BITS-1:0]     active_entries,
    input  logic [icwp_pkg::IDX_BITS-1:0]     entry_index,
    input  logic [15:0]                       use_count,
    input  logic [31:0]                       random_word,
    output logic [5:0]                        picked_index,
    output logic [15:0]                       new_count,
    output logic [1:0]                        status
);
    import icwp_pkg::*;

    logic [COUNT_BITS-1:0] mem [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] rd_reg;
    logic [IDX_BITS-1:0]   ld_idx_reg;
    logic [15:0]           ld_cnt_reg;
    logic [RND_BITS-1:0]   rnd_reg;
    logic [N_BITS-1:0]     idx_reg;
    logic [N_BITS-1:0]     n_val;
    logic [COUNT_BITS-1:0] max_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [SUM_BITS-1:0]   run_reg;
    logic [IDX_BITS-1:0]   pick_reg;
    logic [15:0]           nc_reg;
    logic [1:0]            status_reg;

    // Weight divider: restoring, one quotient bit a cycle.
    logic [NUM_BITS-1:0]   dq_reg;
    logic [COUNT_BITS:0]   drem_reg;
    logic [NUM_CNT_W-1:0]  dcnt_reg;
    logic [COUNT_BITS+1:0] dtrial;

    // Residue unit: random word modulo the weight sum, one bit a cycle.
    logic [RND_BITS-1:0]   mq_reg;
    logic [SUM_BITS:0]     mrem_reg;
    logic [RND_CNT_W-1:0]  mcnt_reg;
    logic [SUM_BITS+1:0]   mtrial;

    always_comb
    begin
        if (active_entries > CFG_BITS'(MAX_ENTRIES))
            n_val = N_BITS'(MAX_ENTRIES);
        else
            n_val = N_BITS'(active_entries);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_load)
            mem[ld_idx_reg] <= COUNT_BITS'(ld_cnt_reg);
        else if (cmd.upd_write)
            mem[pick_reg] <= (rd_reg == COUNT_MAX) ? rd_reg : rd_reg + 1'b1;
        if (cmd.rd)
            rd_reg <= mem[cmd.upd_write ? pick_reg : idx_reg[IDX_BITS-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            ld_idx_reg <= entry_index;
            ld_cnt_reg <= use_count;
            rnd_reg    <= random_word;
            max_reg    <= '0;
        end
        if (cmd.clr_idx)
        begin
            sum_reg <= '0;
            run_reg <= '0;
        end
        if (cmd.max_step && rd_reg > max_reg)
            max_reg <= rd_reg;
        if (cmd.sum_add)
            sum_reg <= sum_reg + SUM_BITS'(dq_reg);
        if (cmd.run_add)
            run_reg <= run_reg + SUM_BITS'(dq_reg);
        if (cmd.set_pick)
            pick_reg <= idx_reg[IDX_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            dcnt_reg   <= '0;
            mcnt_reg   <= '0;
            status_reg <= ST_OK;
            nc_reg     <= '0;
        end
        else
        begin
            if (cmd.clr_idx)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.set_status)
            begin
                status_reg <= cmd.status;
                nc_reg     <= (cmd.status == ST_OK) ?
                              ((rd_reg == COUNT_MAX) ? 16'(rd_reg) : 16'(rd_reg + 1'b1)) :
                              16'd0;
            end
            if (cmd.div_start)
                dcnt_reg <= NUM_CNT_W'(NUM_BITS);
            else if (dcnt_reg != '0)
                dcnt_reg <= dcnt_reg - 1'b1;
            if (cmd.mod_start)
                mcnt_reg <= RND_CNT_W'(RND_BITS);
            else if (mcnt_reg != '0)
                mcnt_reg <= mcnt_reg - 1'b1;
        end
    end

    assign dtrial = {drem_reg, dq_reg[NUM_BITS-1]} - {1'b0, 1'b0, rd_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dq_reg   <= NUM_BITS'({max_reg, 3'b000}) + NUM_BITS'({max_reg, 1'b0});
            drem_reg <= '0;
        end
        else if (dcnt_reg != '0)
        begin
            if (!dtrial[COUNT_BITS+1])
            begin
                drem_reg <= dtrial[COUNT_BITS:0];
                dq_reg   <= {dq_reg[NUM_BITS-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[COUNT_BITS-1:0], dq_reg[NUM_BITS-1]};
                dq_reg   <= {dq_reg[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    assign mtrial = {mrem_reg, mq_reg[RND_BITS-1]} - {2'b00, sum_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mod_start)
        begin
            mq_reg   <= rnd_reg;
            mrem_reg <= '0;
        end
        else if (mcnt_reg != '0)
        begin
            mq_reg <= {mq_reg[RND_BITS-2:0], 1'b0};
            if (!mtrial[SUM_BITS+1])
                mrem_reg <= mtrial[SUM_BITS:0];
            else
                mrem_reg <= {mrem_reg[SUM_BITS-1:0], mq_reg[RND_BITS-1]};
        end
    end

    assign sts.last_idx = (idx_reg == n_val - 1'b1);
    assign sts.n_zero   = (n_val == '0);
    assign sts.rd_zero  = (rd_reg == '0);
    assign sts.div_busy = (dcnt_reg != '0);
    assign sts.mod_busy = (mcnt_reg != '0);
    // The running sum including the weight that the divider has just produced.
    assign sts.run_gt   = (({1'b0, run_reg} + (SUM_BITS+1)'(dq_reg)) > mrem_reg);

    assign picked_index = (status_reg == ST_OK) ? 6'(pick_reg) : 6'd0;
    assign new_count    = nc_reg;
    assign status       = status_reg;

endmodule

/* hw/rtl/icwp_ctrl.sv */
module icwp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic           in_func,
    input  logic           out_busy,
    input  icwp_pkg::sts_t sts,
    output icwp_pkg::cmd_t cmd,
    output logic           in_ready,
    output logic           out_set
);
    import icwp_pkg::*;

    state_t state_reg, state_next;
    logic   func_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            func_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
                func_reg <= in_func;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (in_fire) state_next = S_MAX_RD;
            S_MAX_RD:   state_next = func_reg ? (sts.n_zero ? S_OUT : S_MAX_CHK) : S_IDLE;
            S_MAX_CHK:
            begin
                if (sts.rd_zero)      state_next = S_OUT;
                else if (sts.last_idx) state_next = S_SUM_RD;
                else                  state_next = S_MAX_RD;
            end
            S_SUM_RD:   state_next = S_SUM_DIV;
            S_SUM_DIV:  state_next = S_SUM_ADD;
            S_SUM_ADD:
            begin
                if (!sts.div_busy) state_next = sts.last_idx ? S_MOD : S_SUM_RD;
            end
            S_MOD:      if (!sts.mod_busy) state_next = S_WALK_RD;
            S_WALK_RD:  state_next = S_WALK_DIV;
            S_WALK_DIV: state_next = S_WALK_CHK;
            S_WALK_CHK:
            begin
                if (!sts.div_busy)
                    state_next = (sts.run_gt || sts.last_idx) ? S_UPDATE : S_WALK_RD;
            end
            S_UPDATE:   state_next = S_OUT;
            S_OUT:      if (!out_busy) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // A load writes the table in S_MAX_RD and returns to idle without a result.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        out_set  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_fire;
                cmd.clr_idx   = in_fire;
            end
            S_MAX_RD:
            begin
                cmd.write_load = !func_reg;
                cmd.rd         = func_reg;
                if (func_reg && sts.n_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NO_ACT;
                end
            end
            S_MAX_CHK:
            begin
                cmd.max_step = 1'b1;
                if (sts.rd_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_ZERO_CNT;
                end
                else if (sts.last_idx)
                    cmd.clr_idx = 1'b1;
                else
                    cmd.idx_inc = 1'b1;
            end
            S_SUM_RD:   cmd.rd = 1'b1;
            S_SUM_DIV:  cmd.div_start = 1'b1;
            S_SUM_ADD:
            begin
                if (!sts.div_busy)
                begin
                    cmd.sum_add = 1'b1;
                    if (sts.last_idx) cmd.mod_start = 1'b1;
                    cmd.idx_inc = !sts.last_idx;
                    cmd.clr_idx = sts.last_idx;
                end
            end
            S_MOD:      cmd.mod_start = 1'b0;
            S_WALK_RD:  cmd.rd = 1'b1;
            S_WALK_DIV: cmd.div_start = 1'b1;
            S_WALK_CHK:
            begin
                if (!sts.div_busy)
                begin
                    cmd.run_add  = 1'b1;
                    cmd.set_pick = 1'b1;
                    cmd.idx_inc  = !(sts.run_gt || sts.last_idx);
                end
            end
            S_UPDATE:
            begin
                cmd.rd         = 1'b1;
                cmd.upd_write  = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = ST_OK;
            end
            S_OUT:
            begin
                out_set = func_reg && !out_busy;
            end
            default: ;
        endcase
    end

endmodule

/* hw/rtl/inverse_count_weighted_pick_unit.sv */
// Roulette-wheel pick over a 64-entry table of use counts, biased toward entries
// used least. A load word (func 0) writes one count and gives no result. A pick
// word (func 1) scans the active entries for the largest count, sums the weights
// floor(10*max/count) through a bit-serial divider, reduces random_word modulo
// that sum in a serial unit, walks the entries again until the running sum
// passes the residue, and increments the chosen count with saturation. The
// input is taken only in the idle state, so a pick holds it off until its
// result is registered, and a load holds it off while it writes the table.
// Picks return status 1 when no entry is active and 2 when an active count is
// zero. Table entries must be loaded before a pick reads them.
module inverse_count_weighted_pick_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [icwp_pkg::CFG_BITS-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_tuser,   // func
    input  logic [55:0]                   s_tdata,   // entry_index, use_count, random_word
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata    // picked_index, new_count, status
);
    import icwp_pkg::*;

    logic [CFG_BITS-1:0] active_reg;
    logic                in_fire, out_set, m_valid_reg;
    logic [23:0]         m_data_reg;
    logic [5:0]          pi;
    logic [15:0]         nc;
    logic [1:0]          st;
    cmd_t                cmd;
    sts_t                sts;

    assign in_fire = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= '0;
        else if (cfg_we)
            active_reg <= cfg_wdata;
    end

    icwp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_func  (s_tuser),
        .out_busy (m_valid_reg && !m_tready),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_tready),
        .out_set  (out_set)
    );

    icwp_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .active_entries (active_reg),
        .entry_index    (s_tdata[5:0]),
        .use_count      (s_tdata[21:6]),
        .random_word    (s_tdata[53:22]),
        .picked_index   (pi),
        .new_count      (nc),
        .status         (st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_set)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_set)
            m_data_reg <= {st, nc, pi};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready) else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("output changed");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:22] != 2'd3)) else $error("bad status");
`endif

endmodule

/* dv/tb_inverse_count_weighted_pick_unit.sv */
module tb_inverse_count_weighted_pick_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import icwp_pkg::*;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_PICK = 1'b1;
    localparam int   CYCLE_LIMIT = 10000000;
    // A pick at 64 active entries takes far longer than a load.
    localparam int   DRAIN_CYCLES = 2000;

    typedef struct {
        logic [IDX_BITS-1:0]   idx;
        logic [COUNT_BITS-1:0] cnt;
        logic [1:0]            st;
    } pick_result_t;

    typedef enum logic { ROW_CFG, ROW_WORD } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_BITS-1:0]   cfg;
        logic                  func;
        logic [IDX_BITS-1:0]   idx;
        logic [COUNT_BITS-1:0] cnt;
        logic [RND_BITS-1:0]   rnd;
        bit                    typed;
        pick_result_t          res;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_BITS-1:0]   cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic                  s_tuser;
    logic [55:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;

    logic [COUNT_BITS-1:0] count_model [MAX_ENTRIES];
    logic [CFG_BITS-1:0]   active_model;
    pick_result_t          pending_picks [$];
    row_t                  directed [$];
    int                    errors;
    int                    cycles;
    bit                    hold_req;
    bit                    hold_done;

    inverse_count_weighted_pick_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(20, 200);
    endfunction

    // Roulette pick weighted by floor(10*max/count); updates the count copy.
    function automatic pick_result_t weighted_pick(input logic [RND_BITS-1:0] rnd);
        int                  n;
        int                  sel;
        longint unsigned     mx;
        longint unsigned     total;
        longint unsigned     residue;
        longint unsigned     run;
        pick_result_t        r;
        r.idx = '0;
        r.cnt = '0;
        r.st  = ST_OK;
        n = (active_model > MAX_ENTRIES) ? MAX_ENTRIES : active_model;
        if (n == 0)
        begin
            r.st = ST_NO_ACT;
            return r;
        end
        mx = 0;
        for (int i = 0; i < n; i++)
        begin
            if (count_model[i] == 0)
            begin
                r.st = ST_ZERO_CNT;
                return r;
            end
            if (count_model[i] > mx)
                mx = count_model[i];
        end
        total = 0;
        for (int i = 0; i < n; i++)
            total += (mx * 10) / count_model[i];
        residue = rnd % total;
        run = 0;
        sel = n - 1;
        for (int i = 0; i < n; i++)
        begin
            run += (mx * 10) / count_model[i];
            if (run > residue)
            begin
                sel = i;
                break;
            end
        end
        if (count_model[sel] != COUNT_MAX)
            count_model[sel] = count_model[sel] + 1'b1;
        r.idx = IDX_BITS'(sel);
        r.cnt = count_model[sel];
        return r;
    endfunction

    task automatic write_active(input logic [CFG_BITS-1:0] value);
        s_tvalid <= 1'b0;
        wait (pending_picks.size() == 0);
        // A load still in flight gives no result, so let it settle.
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        active_model = value;
    endtask

    task automatic send_word(input logic func, input logic [IDX_BITS-1:0] idx,
                             input logic [COUNT_BITS-1:0] cnt,
                             input logic [RND_BITS-1:0] rnd,
                             input bit typed, input pick_result_t typed_res);
        int           gap;
        pick_result_t p;
        gap = random_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, rnd, cnt, idx};
        do
            @(posedge clk);
        while (!s_tready);
        if (func == FUNC_LOAD)
            count_model[idx] = cnt;
        else
        begin
            p = weighted_pick(rnd);
            pending_picks.push_back(typed ? typed_res : p);
        end
    endtask

    task automatic add_row(input row_kind_t kind, input logic [CFG_BITS-1:0] cfg,
                           input logic func, input logic [IDX_BITS-1:0] idx,
                           input logic [COUNT_BITS-1:0] cnt,
                           input logic [RND_BITS-1:0] rnd, input bit typed,
                           input logic [IDX_BITS-1:0] e_idx,
                           input logic [COUNT_BITS-1:0] e_cnt, input logic [1:0] e_st);
        row_t row;
        row.kind    = kind;
        row.cfg     = cfg;
        row.func    = func;
        row.idx     = idx;
        row.cnt     = cnt;
        row.rnd     = rnd;
        row.typed   = typed;
        row.res.idx = e_idx;
        row.res.cnt = e_cnt;
        row.res.st  = e_st;
        directed.push_back(row);
    endtask

    // Receiver: random back-pressure, plus one long hold while the input fills up.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_req && !hold_done)
        begin
            m_tready <= 1'b0;
            repeat (5000) @(posedge clk);
            hold_done = 1'b1;
        end
        else if (random_gap() == 0)
            m_tready <= 1'b1;
        else
            m_tready <= 1'b0;
    end

    always @(posedge clk)
    begin
        pick_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_picks.size() == 0)
            begin
                $error("unexpected result word %h", m_tdata);
                errors++;
            end
            else
            begin
                want = pending_picks.pop_front();
                if (m_tdata[5:0] !== want.idx)
                begin
                    $error("picked_index: expected %0d, got %0d", want.idx, m_tdata[5:0]);
                    errors++;
                end
                if (m_tdata[21:6] !== want.cnt)
                begin
                    $error("new_count: expected %0d, got %0d", want.cnt, m_tdata[21:6]);
                    errors++;
                end
                if (m_tdata[23:22] !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, m_tdata[23:22]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int              actives [8];
        int              r;
        logic [COUNT_BITS-1:0] c;
        pick_result_t    none;
        actives = '{2, 5, 3, 1, 64, 100, 0, 8};
        none.idx = '0;
        none.cnt = '0;
        none.st  = ST_OK;
        hold_req = 1'b0;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tuser  = 1'b0;
        s_tdata  = '0;
        active_model = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
            count_model[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Right after reset no entry is active.
        add_row(ROW_WORD, 0, FUNC_PICK, 0, 0, 32'h0, 1, 0, 0, ST_NO_ACT);
        // Single entry: saturation, zero count, plain increment.
        add_row(ROW_CFG, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_WORD, 0, FUNC_LOAD, 0, 16'hFFFF, 0, 0, 0, 0, 0);
        add_row(ROW_WORD, 0, FUNC_PICK, 0, 0, 32'hFFFF_FFFF, 1, 0, 16'hFFFF, ST_OK);
        add_row(ROW_WORD, 0, FUNC_LOAD, 0, 16'h0, 0, 0, 0, 0, 0);
        add_row(ROW_WORD, 0, FUNC_PICK, 0, 0, 32'h1234, 1, 0, 0, ST_ZERO_CNT);
        add_row(ROW_WORD, 0, FUNC_LOAD, 0, 16'h1, 0, 0, 0, 0, 0);
        add_row(ROW_WORD, 0, FUNC_PICK, 0, 0, 32'h0, 1, 0, 16'h2, ST_OK);
        // Full table: the highest entry drives the extremes.
        add_row(ROW_CFG, 64, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_WORD, 0, FUNC_LOAD, 63, 16'hFFFF, 0, 0, 0, 0, 0);
        add_row(ROW_WORD, 0, FUNC_PICK, 0, 0, 32'h0, 0, 0, 0, 0);
        add_row(ROW_WORD, 0, FUNC_PICK, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
        add_row(ROW_WORD, 0, FUNC_LOAD, 63, 16'h0, 0, 0, 0, 0, 0);
        add_row(ROW_WORD, 0, FUNC_PICK, 0, 0, 32'h5555_AAAA, 1, 0, 0, ST_ZERO_CNT);
        add_row(ROW_WORD, 0, FUNC_LOAD, 63, 16'h5, 0, 0, 0, 0, 0);
        add_row(ROW_WORD, 0, FUNC_LOAD, 42, 16'hAAAA, 0, 0, 0, 0, 0);
        add_row(ROW_WORD, 0, FUNC_PICK, 0, 0, 32'h8000_0000, 0, 0, 0, 0);
        // Register beyond the table size acts as the full table.
        add_row(ROW_CFG, 127, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_WORD, 0, FUNC_PICK, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
        add_row(ROW_WORD, 0, FUNC_PICK, 0, 0, 32'h0000_0001, 0, 0, 0, 0);

        foreach (directed[k])
        begin
            if (directed[k].kind == ROW_CFG)
                write_active(directed[k].cfg);
            else
                send_word(directed[k].func, directed[k].idx, directed[k].cnt,
                          directed[k].rnd, directed[k].typed, directed[k].res);
            // Fill the table once so that no pick ever reads an unwritten entry.
            if (k == 0)
                for (int i = 0; i < MAX_ENTRIES; i++)
                    send_word(FUNC_LOAD, IDX_BITS'(i),
                              COUNT_BITS'($urandom_range(1, 50)), $urandom, 0, none);
        end

        foreach (actives[p])
        begin
            write_active(CFG_BITS'(actives[p]));
            if (p == 2)
                hold_req = 1'b1;
            for (int j = 0; j < 40; j++)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    send_word(FUNC_PICK, IDX_BITS'($urandom), COUNT_BITS'($urandom),
                              $urandom, 0, none);
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        c = COUNT_BITS'($urandom_range(1, 20));
                    else if (r < 97)
                        c = COUNT_BITS'($urandom);
                    else
                        c = '0;
                    send_word(FUNC_LOAD, IDX_BITS'($urandom), c, $urandom, 0, none);
                end
            end
        end
        s_tvalid <= 1'b0;

        wait (pending_picks.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
